@@ hdl/nkps_pkg.sv @@
`timescale 1ns / 1ps
package nkps_pkg;
  localparam int RecordBits = 32;
  localparam int KindBits = 8;
  localparam int MapBits = 16;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_EAST  = 3'd0,
    REG_TARGET_NORTH = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_WIN_WEST     = 3'd3,
    REG_WIN_EAST     = 3'd4,
    REG_WIN_SOUTH    = 3'd5,
    REG_WIN_NORTH    = 3'd6,
    REG_KEEP_COUNT   = 3'd7
  } reg_index_t;
endpackage

@@ hdl/nkps_front.sv @@
`timescale 1ns / 1ps
// front part: window test, squared distance and radius test over three stages
module nkps_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nkps_pkg::RecordBits-1:0] in_id,
  input  logic signed [COORD_BITS-1:0]   in_east,
  input  logic signed [COORD_BITS-1:0]   in_north,
  input  logic [nkps_pkg::KindBits-1:0]  in_kind,
  input  logic [nkps_pkg::MapBits-1:0]   in_map,
  input  logic                           in_last,
  input  logic signed [COORD_BITS-1:0]   target_east,
  input  logic signed [COORD_BITS-1:0]   target_north,
  input  logic signed [COORD_BITS:0]     radius_limit,
  input  logic signed [COORD_BITS-1:0]   window_west,
  input  logic signed [COORD_BITS-1:0]   window_east,
  input  logic signed [COORD_BITS-1:0]   window_south,
  input  logic signed [COORD_BITS-1:0]   window_north,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nkps_pkg::RecordBits-1:0] out_id,
  output logic [COORD_BITS-1:0]          out_east,
  output logic [COORD_BITS-1:0]          out_north,
  output logic [nkps_pkg::KindBits-1:0]  out_kind,
  output logic [nkps_pkg::MapBits-1:0]   out_map,
  output logic [2*COORD_BITS+1:0]        out_dist,
  output logic                           out_pass,
  output logic                           out_last
);
  localparam int DB = 2 * COORD_BITS + 2;
  localparam int HB = 2 * COORD_BITS + 2;

  logic                          v1, v2, v3;
  logic                          adv;
  logic [nkps_pkg::RecordBits-1:0] id1, id2;
  logic [COORD_BITS-1:0]         e1, n1, e2, n2;
  logic [nkps_pkg::KindBits-1:0] k1, k2;
  logic [nkps_pkg::MapBits-1:0]  m1, m2;
  logic                          l1, l2, w1, w2;
  logic [COORD_BITS:0]           de, dn;
  logic [COORD_BITS:0]           rmag;
  logic [HB-1:0]                 sqe, sqn, sqr;
  logic [DB-1:0]                 d2;
  logic                          rneg, rzero;
  logic signed [COORD_BITS:0]    de_s, dn_s;
  logic                          win;
  logic                          circ_ok;

  // whole pipe moves when its last stage is free
  assign adv = !v3 || out_ready;
  assign in_ready = adv;
  assign out_valid = v3;

  assign win = (in_east >= window_west) && (in_east <= window_east) &&
               (in_north >= window_south) && (in_north <= window_north);
  assign de_s = {in_east[COORD_BITS-1], in_east} - {target_east[COORD_BITS-1], target_east};
  assign dn_s = {in_north[COORD_BITS-1], in_north} - {target_north[COORD_BITS-1], target_north};

  // stage 1: differences as magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      id1 <= in_id; e1 <= in_east; n1 <= in_north; k1 <= in_kind; m1 <= in_map;
      l1 <= in_last; w1 <= win;
      de <= de_s[COORD_BITS] ? -de_s : de_s;
      dn <= dn_s[COORD_BITS] ? -dn_s : dn_s;
      rmag <= radius_limit[COORD_BITS] ? -radius_limit : radius_limit;
      rneg <= radius_limit[COORD_BITS];
      rzero <= (radius_limit == '0);
      // stage 2: squares
      id2 <= id1; e2 <= e1; n2 <= n1; k2 <= k1; m2 <= m1; l2 <= l1; w2 <= w1;
      sqe <= HB'(de) * HB'(de);
      sqn <= HB'(dn) * HB'(dn);
      sqr <= HB'(rmag) * HB'(rmag);
      // stage 3: sum and radius test
      out_id <= id2; out_east <= e2; out_north <= n2; out_kind <= k2; out_map <= m2;
      out_last <= l2;
      out_dist <= d2;
      out_pass <= w2 && circ_ok;
    end
  end

  assign d2 = sqe + sqn;
  assign circ_ok = rzero || (rneg ? (d2 > sqr) : (d2 <= sqr));
endmodule

@@ hdl/nkps_back.sv @@
`timescale 1ns / 1ps
// back part: sorted insertion list, one shift step per record, and the report
module nkps_back #(
  parameter int KEEP_DEPTH = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nkps_pkg::RecordBits-1:0] in_id,
  input  logic [COORD_BITS-1:0]          in_east,
  input  logic [COORD_BITS-1:0]          in_north,
  input  logic [nkps_pkg::KindBits-1:0]  in_kind,
  input  logic [nkps_pkg::MapBits-1:0]   in_map,
  input  logic [2*COORD_BITS+1:0]        in_dist,
  input  logic                           in_pass,
  input  logic                           in_last,
  input  logic [4:0]                     keep_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [nkps_pkg::RecordBits-1:0] out_id,
  output logic [COORD_BITS-1:0]          out_east,
  output logic [COORD_BITS-1:0]          out_north,
  output logic [nkps_pkg::KindBits-1:0]  out_kind,
  output logic [nkps_pkg::MapBits-1:0]   out_map,
  output logic [2*COORD_BITS+1:0]        out_dist,
  output logic                           out_none,
  output logic                           out_last
);
  localparam int DB = 2 * COORD_BITS + 2;
  localparam int EB = nkps_pkg::RecordBits + 2 * COORD_BITS + nkps_pkg::KindBits +
                      nkps_pkg::MapBits;
  localparam int CB = $clog2(KEEP_DEPTH + 1);
  localparam int IB = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;

  typedef enum logic [1:0] {S_TAKE, S_REPORT, S_NONE} state_t;

  state_t            state;
  logic [EB-1:0]     ent [KEEP_DEPTH];
  logic [DB-1:0]     dst [KEEP_DEPTH];
  logic [CB-1:0]     total;
  logic [CB-1:0]     rd;
  logic [CB-1:0]     limit;
  logic [CB-1:0]     slot;
  logic [EB-1:0]     new_ent;
  logic              take, do_ins, grow;
  logic              out_full;
  logic              load;
  logic [IB-1:0]     rd_ix;

  assign limit = (keep_count == 5'd0) ? CB'(1) :
                 ((32'(keep_count) > KEEP_DEPTH) ? CB'(KEEP_DEPTH) : CB'(keep_count));
  assign grow = total < limit;
  assign new_ent = {in_id, in_east, in_north, in_kind, in_map};
  assign in_ready = (state == S_TAKE);
  assign take = in_valid && in_ready;
  assign do_ins = take && in_pass &&
                  (grow || (total != '0 && in_dist < dst[IB'(total - CB'(1))]));
  // slot the new entry fills before shifting: end of list
  assign slot = grow ? total : total - CB'(1);
  assign out_valid = out_full;
  assign rd_ix = rd[IB-1:0];
  // output register takes a new result
  assign load = (state inside {S_REPORT, S_NONE}) && (!out_full || out_ready);

  // parallel compare and shift of every list entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      if (do_ins && CB'(i) <= slot) begin
        if (i > 0 && dst[i-1] > in_dist && CB'(i - 1) < slot + CB'(0)) begin
          ent[i] <= ent[i-1];
          dst[i] <= dst[i-1];
        end else if (CB'(i) == slot || dst[i] > in_dist) begin
          ent[i] <= new_ent;
          dst[i] <= in_dist;
        end
      end
    end
  end

  // control and report sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      total <= '0;
      rd <= '0;
      out_full <= 1'b0;
    end else begin
      if (load) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
      case (state)
        S_TAKE: begin
          if (take) begin
            if (do_ins && grow) total <= total + CB'(1);
            if (in_last) begin
              rd <= '0;
              state <= ((total == '0) && !do_ins) ? S_NONE : S_REPORT;
            end
          end
        end
        S_REPORT: begin
          if (load) begin
            {out_id, out_east, out_north, out_kind, out_map} <= ent[rd_ix];
            out_dist <= dst[rd_ix];
            out_none <= 1'b0;
            out_last <= (rd + CB'(1) == total);
            rd <= rd + CB'(1);
            if (rd + CB'(1) == total) begin
              total <= '0;
              state <= S_TAKE;
            end
          end
        end
        S_NONE: begin
          if (load) begin
            out_id <= '0; out_east <= '0; out_north <= '0; out_kind <= '0;
            out_map <= '0; out_dist <= '0;
            out_none <= 1'b1;
            out_last <= 1'b1;
            state <= S_TAKE;
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end
endmodule

@@ hdl/nearest_k_point_select.sv @@
`timescale 1ns / 1ps
// a record passes the front stages, then enters the kept list; a report starts once
//   the final record has passed the same stages and entered the back part
// throughput: one record per cycle unless held by a report or an output stall;
//   a report sends one result per kept entry (one if none) before records resume
// reset: synchronous, registers to their reset values, kept list emptied
module nearest_k_point_select #(
  parameter int KEEP_DEPTH = 16,
  parameter int COORD_BITS = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // record_id, point_east, point_north, feature_kind, map_id, zero fill
  input  logic [((32 + 2 * COORD_BITS + 24 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_record_id, out_east, out_north, out_kind, out_map_id, distance_squared, fill
  output logic [((32 + 4 * COORD_BITS + 26 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // none_found
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [COORD_BITS:0] cfg_data
);
  localparam int CW = COORD_BITS;
  localparam int DB = 2 * CW + 2;
  localparam int OW = ((32 + 4 * CW + 26 + 7) / 8) * 8;

  logic signed [CW-1:0] target_east, target_north;
  logic signed [CW:0]   radius_limit;
  logic signed [CW-1:0] window_west, window_east, window_south, window_north;
  logic [4:0]           keep_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_east <= '0;
      target_north <= '0;
      radius_limit <= '0;
      window_west <= {1'b1, {(CW-1){1'b0}}};
      window_east <= {1'b0, {(CW-1){1'b1}}};
      window_south <= {1'b1, {(CW-1){1'b0}}};
      window_north <= {1'b0, {(CW-1){1'b1}}};
      keep_count <= 5'd1;
    end else if (cfg_we) begin
      case (nkps_pkg::reg_index_t'(cfg_index))
        nkps_pkg::REG_TARGET_EAST:  target_east <= cfg_data[CW-1:0];
        nkps_pkg::REG_TARGET_NORTH: target_north <= cfg_data[CW-1:0];
        nkps_pkg::REG_RADIUS:       radius_limit <= cfg_data;
        nkps_pkg::REG_WIN_WEST:     window_west <= cfg_data[CW-1:0];
        nkps_pkg::REG_WIN_EAST:     window_east <= cfg_data[CW-1:0];
        nkps_pkg::REG_WIN_SOUTH:    window_south <= cfg_data[CW-1:0];
        nkps_pkg::REG_WIN_NORTH:    window_north <= cfg_data[CW-1:0];
        nkps_pkg::REG_KEEP_COUNT:   keep_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic            f_valid, f_ready, f_pass, f_last;
  logic [31:0]     f_id;
  logic [CW-1:0]   f_east, f_north;
  logic [7:0]      f_kind;
  logic [15:0]     f_map;
  logic [DB-1:0]   f_dist;
  logic [31:0]     o_id;
  logic [CW-1:0]   o_east, o_north;
  logic [7:0]      o_kind;
  logic [15:0]     o_map;
  logic [DB-1:0]   o_dist;

  nkps_front #(.COORD_BITS(CW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_id(s_axis_tdata[31:0]),
    .in_east(s_axis_tdata[32+CW-1:32]),
    .in_north(s_axis_tdata[32+2*CW-1:32+CW]),
    .in_kind(s_axis_tdata[32+2*CW+7:32+2*CW]),
    .in_map(s_axis_tdata[32+2*CW+23:32+2*CW+8]),
    .in_last(s_axis_tlast),
    .target_east(target_east), .target_north(target_north),
    .radius_limit(radius_limit),
    .window_west(window_west), .window_east(window_east),
    .window_south(window_south), .window_north(window_north),
    .out_valid(f_valid), .out_ready(f_ready),
    .out_id(f_id), .out_east(f_east), .out_north(f_north),
    .out_kind(f_kind), .out_map(f_map), .out_dist(f_dist),
    .out_pass(f_pass), .out_last(f_last)
  );

  nkps_back #(.KEEP_DEPTH(KEEP_DEPTH), .COORD_BITS(CW)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready),
    .in_id(f_id), .in_east(f_east), .in_north(f_north),
    .in_kind(f_kind), .in_map(f_map), .in_dist(f_dist),
    .in_pass(f_pass), .in_last(f_last),
    .keep_count(keep_count),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_id(o_id), .out_east(o_east), .out_north(o_north),
    .out_kind(o_kind), .out_map(o_map), .out_dist(o_dist),
    .out_none(m_axis_tuser), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = OW'({o_dist, o_map, o_kind, o_north, o_east, o_id});

`ifndef SYNTH
  // a none-found result is always the last of its report
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("none found result without last");
  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif
endmodule

@@ tb/sv/tb_nearest_k_point_select.sv @@
`timescale 1ns / 1ps
module tb_nearest_k_point_select;
  localparam int KeepDepth = 16;
  localparam int CoordBits = 24;
  localparam int InBits = ((32 + 2 * CoordBits + 24 + 7) / 8) * 8;
  localparam int OutBits = ((32 + 4 * CoordBits + 26 + 7) / 8) * 8;
  localparam longint CoordMin = -(64'sd1 <<< (CoordBits - 1));
  localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;

  typedef struct {
    logic [31:0] id;
    logic signed [23:0] east;
    logic signed [23:0] north;
    logic [7:0] kind;
    logic [15:0] map;
    logic [49:0] dsq;
    logic none;
    logic last;
  } point_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // record_id, point_east, point_north, feature_kind, map_id
  logic [InBits-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // out_record_id, out_east, out_north, out_kind, out_map_id, distance_squared, fill
  logic [OutBits-1:0] m_axis_tdata;
  // none_found
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CoordBits:0] cfg_data = '0;

  // predictor copy of the registers and the kept list
  logic signed [23:0] tgt_east, tgt_north, win_west, win_east, win_south, win_north;
  logic signed [24:0] radius;
  logic [4:0] keep_count;
  point_report_t nearest_list[KeepDepth];
  int nearest_total;
  point_report_t report_q[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int next_id = 0;

  nearest_k_point_select u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // registers back to reset values, list empty
  function automatic void reset_model();
    tgt_east = '0;
    tgt_north = '0;
    radius = '0;
    win_west = 24'sh800000;
    win_east = 24'sh7fffff;
    win_south = 24'sh800000;
    win_north = 24'sh7fffff;
    keep_count = 5'd1;
    nearest_total = 0;
  endfunction

  // filter one record, insert it into the sorted list, report on the final one
  function automatic void predict_record(input logic [31:0] id, input logic signed [23:0] pe,
                                         input logic signed [23:0] pn, input logic [7:0] kind,
                                         input logic [15:0] map, input logic fin);
    longint de, dn, d2, r, r2;
    int lim, slot, pos;
    bit pass;
    point_report_t item;
    pass = !(pe < win_west || pe > win_east || pn < win_south || pn > win_north);
    de = longint'(pe) - longint'(tgt_east);
    dn = longint'(pn) - longint'(tgt_north);
    d2 = de * de + dn * dn;
    r = longint'(radius);
    r2 = r * r;
    if (r > 0 && d2 > r2) pass = 0;
    if (r < 0 && d2 <= r2) pass = 0;
    if (pass) begin
      lim = keep_count;
      if (lim == 0) lim = 1;
      if (lim > KeepDepth) lim = KeepDepth;
      if (nearest_total < lim) begin
        slot = nearest_total;
        nearest_total++;
      end else if (d2 < longint'(nearest_list[nearest_total-1].dsq)) begin
        slot = nearest_total - 1;
      end else begin
        pass = 0;
      end
    end
    if (pass) begin
      pos = slot;
      while (pos > 0 && longint'(nearest_list[pos-1].dsq) > d2) begin
        nearest_list[pos] = nearest_list[pos-1];
        pos--;
      end
      item = '{id, pe, pn, kind, map, d2[49:0], 1'b0, 1'b0};
      nearest_list[pos] = item;
    end
    if (fin) begin
      if (nearest_total == 0) begin
        item = '{'0, '0, '0, '0, '0, '0, 1'b1, 1'b1};
        report_q.push_back(item);
      end else begin
        for (int i = 0; i < nearest_total; i++) begin
          item = nearest_list[i];
          item.last = (i == nearest_total - 1);
          report_q.push_back(item);
        end
      end
      nearest_total = 0;
    end
  endfunction

  function automatic logic signed [23:0] clamp_coord(input longint v);
    if (v < CoordMin) return CoordMin[23:0];
    if (v > CoordMax) return CoordMax[23:0];
    return v[23:0];
  endfunction

  // send one record request and wait for it to be taken
  task automatic send_record(input logic [31:0] id, input logic signed [23:0] pe,
                             input logic signed [23:0] pn, input logic [7:0] kind,
                             input logic [15:0] map, input logic fin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {map, kind, pn, pe, id};
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
    predict_record(id, pe, pn, kind, map, fin);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_near(input int spread, input logic fin);
    logic signed [23:0] pe, pn;
    pe = clamp_coord(longint'(tgt_east) + $urandom_range(0, 2 * spread) - spread);
    pn = clamp_coord(longint'(tgt_north) + $urandom_range(0, 2 * spread) - spread);
    next_id++;
    send_record(next_id, pe, pn, $urandom, $urandom, fin);
  endtask

  task automatic send_any(input logic fin);
    send_record($urandom, $urandom, $urandom, $urandom, $urandom, fin);
  endtask

  // sender stops until every expected result has come and the pipe is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input nkps_pkg::reg_index_t idx, input longint value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CoordBits:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      nkps_pkg::REG_TARGET_EAST:  tgt_east = value[23:0];
      nkps_pkg::REG_TARGET_NORTH: tgt_north = value[23:0];
      nkps_pkg::REG_RADIUS:       radius = value[24:0];
      nkps_pkg::REG_WIN_WEST:     win_west = value[23:0];
      nkps_pkg::REG_WIN_EAST:     win_east = value[23:0];
      nkps_pkg::REG_WIN_SOUTH:    win_south = value[23:0];
      nkps_pkg::REG_WIN_NORTH:    win_north = value[23:0];
      nkps_pkg::REG_KEEP_COUNT:   keep_count = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic full_window();
    write_reg(nkps_pkg::REG_WIN_WEST, CoordMin);
    write_reg(nkps_pkg::REG_WIN_EAST, CoordMax);
    write_reg(nkps_pkg::REG_WIN_SOUTH, CoordMin);
    write_reg(nkps_pkg::REG_WIN_NORTH, CoordMax);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin : ready_gen
    static int seen_asks = 0;
    static int hold_left = 0;
    if (hold_asks != seen_asks) begin
      seen_asks = hold_asks;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each accepted result with the oldest expected one
  always @(posedge clk) begin : report_check
    point_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (report_q.size() == 0) begin
        $display("%0t unexpected result: expected none, got data %h none %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (m_axis_tdata[31:0] !== want.id || m_axis_tdata[55:32] !== want.east ||
            m_axis_tdata[79:56] !== want.north || m_axis_tdata[87:80] !== want.kind ||
            m_axis_tdata[103:88] !== want.map || m_axis_tdata[153:104] !== want.dsq ||
            m_axis_tuser !== want.none || m_axis_tlast !== want.last) begin
          $display("%0t mismatch: expected id %h e %h n %h kind %h map %h d2 %h none %b last %b",
                   $time, want.id, want.east, want.north, want.kind, want.map, want.dsq,
                   want.none, want.last);
          $display("%0t           actual id %h e %h n %h kind %h map %h d2 %h none %b last %b",
                   $time, m_axis_tdata[31:0], m_axis_tdata[55:32], m_axis_tdata[79:56],
                   m_axis_tdata[87:80], m_axis_tdata[103:88], m_axis_tdata[153:104],
                   m_axis_tuser, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // reset values: full window, one kept, extreme coordinates and fields
  task automatic test_reset_defaults();
    send_record(32'hffffffff, 24'sh800000, 24'sh800000, 8'hff, 16'hffff, 1'b0);
    send_record(32'h0, 24'sh7fffff, 24'sh7fffff, 8'h0, 16'h0, 1'b1);
    send_record(32'h5, 24'sh0, 24'sh0, 8'h5a, 16'ha5a5, 1'b1);
    drain();
  endtask

  // inverted window passes nothing, report is none found
  task automatic test_empty_report();
    write_reg(nkps_pkg::REG_WIN_WEST, 10);
    write_reg(nkps_pkg::REG_WIN_EAST, -10);
    send_record(1, 0, 0, 1, 1, 1'b1);
    drain();
    full_window();
    write_reg(nkps_pkg::REG_WIN_SOUTH, 5);
    write_reg(nkps_pkg::REG_WIN_NORTH, 4);
    send_record(2, 0, 4, 1, 1, 1'b0);
    send_record(3, 0, 5, 1, 1, 1'b1);
    drain();
    full_window();
  endtask

  // full depth with ties, keep count zero and above depth
  task automatic test_keep_limits();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 16);
    for (int i = 0; i < 20; i++) send_near(2, i == 19);
    drain();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 0);
    for (int i = 0; i < 4; i++) send_near(3, i == 3);
    drain();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 31);
    for (int i = 0; i < 20; i++) send_near(3, i == 19);
    drain();
  endtask

  // circle beyond and on the boundary, negative radius and the extreme radii
  task automatic test_radius();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 8);
    write_reg(nkps_pkg::REG_RADIUS, 5);
    send_record(10, 3, 4, 0, 0, 1'b0);
    send_record(11, 3, 5, 0, 0, 1'b0);
    send_record(12, -5, 0, 0, 0, 1'b1);
    drain();
    write_reg(nkps_pkg::REG_RADIUS, -5);
    send_record(13, 3, 4, 0, 0, 1'b0);
    send_record(14, 4, 4, 0, 0, 1'b1);
    drain();
    write_reg(nkps_pkg::REG_RADIUS, -16777216);
    send_record(15, 24'sh7fffff, 24'sh7fffff, 0, 0, 1'b1);
    drain();
    write_reg(nkps_pkg::REG_TARGET_EAST, CoordMin);
    write_reg(nkps_pkg::REG_TARGET_NORTH, CoordMin);
    send_record(16, 24'sh7fffff, 24'sh7fffff, 0, 0, 1'b1);
    drain();
    write_reg(nkps_pkg::REG_RADIUS, 16777215);
    send_record(17, 24'sh7fffff, 24'sh7fffff, 0, 0, 1'b1);
    drain();
    write_reg(nkps_pkg::REG_RADIUS, 0);
    write_reg(nkps_pkg::REG_TARGET_EAST, 0);
    write_reg(nkps_pkg::REG_TARGET_NORTH, 0);
  endtask

  // keep count lowered with entries already kept
  task automatic test_keep_lowered();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 6);
    for (int i = 0; i < 6; i++) send_near(20, 1'b0);
    drain();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 2);
    for (int i = 0; i < 4; i++) send_near(20, i == 3);
    drain();
  endtask

  // random sets under random registers
  task automatic test_random(input int items);
    int sent, len, mode;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(2) == 0) begin
        drain();
        write_reg(nkps_pkg::REG_TARGET_EAST, $signed($urandom) >>> 8);
        write_reg(nkps_pkg::REG_TARGET_NORTH, $signed($urandom) >>> 8);
        mode = $urandom_range(3);
        write_reg(nkps_pkg::REG_RADIUS, mode == 0 ? 0 : mode == 1 ? $urandom_range(1, 12) :
                  mode == 2 ? -$urandom_range(1, 8) : $signed($urandom) >>> 7);
        if ($urandom_range(1) == 0) begin
          full_window();
        end else begin
          write_reg(nkps_pkg::REG_WIN_WEST, longint'(tgt_east) - $urandom_range(0, 10));
          write_reg(nkps_pkg::REG_WIN_EAST, longint'(tgt_east) + $urandom_range(0, 10) - 2);
          write_reg(nkps_pkg::REG_WIN_SOUTH, longint'(tgt_north) - $urandom_range(0, 10));
          write_reg(nkps_pkg::REG_WIN_NORTH,
                    longint'(tgt_north) + $urandom_range(0, 10) - 2);
        end
        write_reg(nkps_pkg::REG_KEEP_COUNT, $urandom_range(0, 31));
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) < 7) send_near(10, i == len - 1);
        else send_any(i == len - 1);
      end
      sent += len;
    end
    drain();
  endtask

  // long receiver hold-off while records and reports keep coming
  task automatic test_backpressure();
    write_reg(nkps_pkg::REG_KEEP_COUNT, 4);
    hold_asks++;
    for (int i = 0; i < 40; i++) send_near(15, (i % 5) == 4);
    drain();
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_empty_report();
    test_keep_limits();
    test_radius();
    test_keep_lowered();
    test_backpressure();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(35);
    send_idle_pct = 45; recv_stall_pct = 0;  test_random(35);
    send_idle_pct = 0;  recv_stall_pct = 45; test_random(35);
    send_idle_pct = 18; recv_stall_pct = 18; test_random(35);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
